@@ design/http_header_line_parser_macros.svh @@
// Assertion macros for the header line parser.
`ifndef HTTP_HEADER_LINE_PARSER_MACROS_SVH
`define HTTP_HEADER_LINE_PARSER_MACROS_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define HHLP_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define HHLP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`else

`define HHLP_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define HHLP_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

@@ design/hhlp_pkg.sv @@
package hhlp_pkg;

   typedef enum logic [2:0] {
      PH_KEY,
      PH_START_CR,
      PH_LEAD,
      PH_VAL,
      PH_CR,
      PH_SKIP
   } phase_type;

   localparam logic [2:0] STATUS_END       = 3'd0;
   localparam logic [2:0] STATUS_OTHER     = 3'd1;
   localparam logic [2:0] STATUS_TYPE      = 3'd2;
   localparam logic [2:0] STATUS_LENGTH    = 3'd3;
   localparam logic [2:0] STATUS_MALFORMED = 3'd4;

   localparam logic [2:0] MEDIA_UNKNOWN = 3'd0;

   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;

   localparam int TEXT_BITS = 8 * 24;
   localparam int KEY_COUNT = 2;
   localparam int MEDIA_COUNT = 4;

   // Texts are right-justified: the last character sits in the low byte.
   localparam logic [TEXT_BITS-1:0] KEY_TEXT [KEY_COUNT] = '{
      "content-type",
      "content-length"
   };
   localparam logic [4:0] KEY_LEN [KEY_COUNT] = '{5'd12, 5'd14};

   localparam logic [TEXT_BITS-1:0] MEDIA_TEXT [MEDIA_COUNT] = '{
      "text/plain",
      "application/octet-stream",
      "application/json",
      "application/td+json"
   };
   localparam logic [4:0] MEDIA_LEN [MEDIA_COUNT] = '{5'd10, 5'd24, 5'd16, 5'd19};

   function automatic logic [7:0] to_lower(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
         r = c + 8'd32;
      end
      return r;
   endfunction

   // True when the text has a character at pos and it equals c.
   function automatic logic char_match(input logic [TEXT_BITS-1:0] text,
                                       input logic [4:0] len,
                                       input logic [4:0] pos,
                                       input logic [7:0] c);
      logic [4:0] back;
      logic [TEXT_BITS-1:0] shifted;
      back = len - 5'd1 - pos;
      shifted = text >> {back, 3'b000};
      return (pos < len) && (shifted[7:0] == c);
   endfunction

endpackage

@@ design/http_header_line_parser.sv @@
// Header line parser: one header word per cycle unless the result register is stalled,
// one result per line at its LF. An accepted word is held in the input register, is
// decoded out of it, and its result lands in the result register when that is free.
// Throughput: one word per cycle unless stalled; the per-byte match update is combinational.
// Reset (synchronous, active high) empties both registers and starts a new line.
`include "http_header_line_parser_macros.svh"

module http_header_line_parser #(
   parameter int LENGTH_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_line_status,
   output logic [2:0]  rsp_media_type,
   output logic [31:0] rsp_body_length
);

   localparam int PROD_BITS = LENGTH_BITS + 4;

   // Input register.
   logic       stage_valid_ff, stage_valid_in;
   logic [7:0] stage_byte_ff, stage_byte_in;

   // Line state.
   hhlp_pkg::phase_type    phase_ff, phase_in;
   logic [4:0]             pos_ff, pos_in;
   logic [1:0]             kflags_ff, kflags_in;
   logic [3:0]             vflags_ff, vflags_in;
   logic [3:0]             vtok_ff, vtok_in;
   logic [LENGTH_BITS-1:0] acc_ff, acc_in;
   logic                   num_active_ff, num_active_in;
   logic                   num_ovf_ff, num_ovf_in;
   logic                   line_error_ff, line_error_in;

   // Result register.
   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  rsp_status_ff, rsp_status_in;
   logic [2:0]  rsp_media_ff, rsp_media_in;
   logic [31:0] rsp_length_ff, rsp_length_in;

   logic        out_free, advance, accept;
   logic        res_valid;
   logic [2:0]  res_status, res_media;
   logic [31:0] res_length;

   logic [7:0] c, lc;
   logic       is_lf, is_cr, is_colon, is_blank, is_digit;
   logic [1:0] key_hit, key_done;
   logic [3:0] media_hit, media_done;
   logic [PROD_BITS-1:0]   acc_wide, prod;
   logic                   prod_ovf;
   logic [LENGTH_BITS+31:0] acc_ext;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = stage_valid_ff && out_free;
   assign req_stall = stage_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;

   assign c        = stage_byte_ff;
   assign lc       = hhlp_pkg::to_lower(c);
   assign is_lf    = (c == hhlp_pkg::CHAR_LF);
   assign is_cr    = (c == hhlp_pkg::CHAR_CR);
   assign is_colon = (c == hhlp_pkg::CHAR_COLON);
   assign is_blank = (c == hhlp_pkg::CHAR_SPACE) || (c == hhlp_pkg::CHAR_TAB);
   assign is_digit = (c >= hhlp_pkg::CHAR_ZERO) && (c <= hhlp_pkg::CHAR_NINE);

   always_comb begin
      for (int k = 0; k < hhlp_pkg::KEY_COUNT; k++) begin
         key_hit[k]  = hhlp_pkg::char_match(hhlp_pkg::KEY_TEXT[k], hhlp_pkg::KEY_LEN[k],
                                            pos_ff, lc);
         key_done[k] = kflags_ff[k] && (pos_ff == hhlp_pkg::KEY_LEN[k]);
      end
      for (int k = 0; k < hhlp_pkg::MEDIA_COUNT; k++) begin
         media_hit[k]  = hhlp_pkg::char_match(hhlp_pkg::MEDIA_TEXT[k],
                                              hhlp_pkg::MEDIA_LEN[k], pos_ff, lc);
         media_done[k] = vflags_ff[k] && (pos_ff == hhlp_pkg::MEDIA_LEN[k]);
      end
   end

   // acc * 10 + digit, with the top bits telling whether it left the length range.
   assign acc_wide = {4'b0000, acc_ff};
   assign prod     = (acc_wide << 3) + (acc_wide << 1)
                   + {{(PROD_BITS-4){1'b0}}, c[3:0]};
   assign prod_ovf = |prod[PROD_BITS-1:LENGTH_BITS];
   assign acc_ext  = {32'd0, acc_ff};

   // Next line phase.
   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff) inside
         hhlp_pkg::PH_KEY, hhlp_pkg::PH_START_CR: begin
            if (is_lf) begin
               phase_in = hhlp_pkg::PH_KEY;
            end else if (is_colon) begin
               phase_in = hhlp_pkg::PH_LEAD;
            end else if (is_cr && pos_ff == 5'd0) begin
               phase_in = hhlp_pkg::PH_START_CR;
            end else begin
               phase_in = hhlp_pkg::PH_KEY;
            end
         end
         hhlp_pkg::PH_LEAD, hhlp_pkg::PH_VAL: begin
            if (is_lf) begin
               phase_in = hhlp_pkg::PH_KEY;
            end else if (is_cr) begin
               phase_in = hhlp_pkg::PH_CR;
            end else if (!is_blank) begin
               phase_in = hhlp_pkg::PH_VAL;
            end
         end
         hhlp_pkg::PH_CR: begin
            phase_in = is_lf ? hhlp_pkg::PH_KEY : hhlp_pkg::PH_SKIP;
         end
         default: begin
            phase_in = is_lf ? hhlp_pkg::PH_KEY : hhlp_pkg::PH_SKIP;
         end
      endcase
   end

   // Per-byte datapath and the result of a line.
   always_comb begin
      pos_in        = pos_ff;
      kflags_in     = kflags_ff;
      vflags_in     = vflags_ff;
      vtok_in       = vtok_ff;
      acc_in        = acc_ff;
      num_active_in = num_active_ff;
      num_ovf_in    = num_ovf_ff;
      line_error_in = line_error_ff;
      res_valid     = 1'b0;
      res_status    = hhlp_pkg::STATUS_OTHER;
      res_media     = hhlp_pkg::MEDIA_UNKNOWN;
      res_length    = 32'd0;

      unique case (phase_ff) inside
         hhlp_pkg::PH_KEY, hhlp_pkg::PH_START_CR: begin
            if (is_lf) begin
               res_valid  = 1'b1;
               res_status = (phase_ff == hhlp_pkg::PH_START_CR) ?
                            hhlp_pkg::STATUS_END : hhlp_pkg::STATUS_MALFORMED;
            end else if (is_colon) begin
               kflags_in = key_done;
               pos_in    = 5'd0;
            end else begin
               kflags_in = kflags_ff & key_hit;
               if (pos_ff != 5'd31) begin
                  pos_in = pos_ff + 5'd1;
               end
            end
         end
         hhlp_pkg::PH_LEAD, hhlp_pkg::PH_VAL: begin
            if (is_lf) begin
               res_valid  = 1'b1;
               res_status = hhlp_pkg::STATUS_MALFORMED;
            end else if (is_cr || (is_blank && phase_ff == hhlp_pkg::PH_VAL)) begin
               // The value ends here; a later non-blank undoes any media match.
               vtok_in       = vtok_ff | media_done;
               vflags_in     = 4'd0;
               num_active_in = 1'b0;
            end else if (!is_blank) begin
               vtok_in   = 4'd0;
               vflags_in = vflags_ff & media_hit;
               if (pos_ff != 5'd31) begin
                  pos_in = pos_ff + 5'd1;
               end
               if (num_active_ff) begin
                  if (!is_digit) begin
                     num_active_in = 1'b0;
                  end else if (prod_ovf) begin
                     num_ovf_in = 1'b1;
                  end else begin
                     acc_in = prod[LENGTH_BITS-1:0];
                  end
               end
            end
         end
         hhlp_pkg::PH_CR: begin
            if (is_lf) begin
               res_valid = 1'b1;
               if (line_error_ff) begin
                  res_status = hhlp_pkg::STATUS_MALFORMED;
               end else if (kflags_ff[0]) begin
                  res_status = hhlp_pkg::STATUS_TYPE;
                  for (int k = hhlp_pkg::MEDIA_COUNT - 1; k >= 0; k--) begin
                     if (vtok_ff[k]) begin
                        res_media = 3'(k + 1);
                     end
                  end
               end else if (kflags_ff[1]) begin
                  if (num_ovf_ff) begin
                     res_status = hhlp_pkg::STATUS_MALFORMED;
                  end else begin
                     res_status = hhlp_pkg::STATUS_LENGTH;
                     res_length = acc_ext[31:0];
                  end
               end
            end else begin
               line_error_in = 1'b1;
            end
         end
         default: begin
            if (is_lf) begin
               res_valid  = 1'b1;
               res_status = hhlp_pkg::STATUS_MALFORMED;
            end
         end
      endcase

      // Every result closes the line.
      if (res_valid) begin
         pos_in        = 5'd0;
         kflags_in     = 2'b11;
         vflags_in     = 4'b1111;
         vtok_in       = 4'd0;
         acc_in        = '0;
         num_active_in = 1'b1;
         num_ovf_in    = 1'b0;
         line_error_in = 1'b0;
      end
   end

   assign stage_valid_in = accept ? 1'b1 : (stage_valid_ff && !advance);
   assign stage_byte_in  = accept ? req_data_byte : stage_byte_ff;

   assign rsp_valid_in  = (advance && res_valid) ? 1'b1 : (rsp_valid_ff && rsp_stall);
   assign rsp_status_in = (advance && res_valid) ? res_status : rsp_status_ff;
   assign rsp_media_in  = (advance && res_valid) ? res_media : rsp_media_ff;
   assign rsp_length_in = (advance && res_valid) ? res_length : rsp_length_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         phase_ff       <= hhlp_pkg::PH_KEY;
         pos_ff         <= 5'd0;
         kflags_ff      <= 2'b11;
         vflags_ff      <= 4'b1111;
         vtok_ff        <= 4'd0;
         acc_ff         <= '0;
         num_active_ff  <= 1'b1;
         num_ovf_ff     <= 1'b0;
         line_error_ff  <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (advance) begin
            phase_ff      <= phase_in;
            pos_ff        <= pos_in;
            kflags_ff     <= kflags_in;
            vflags_ff     <= vflags_in;
            vtok_ff       <= vtok_in;
            acc_ff        <= acc_in;
            num_active_ff <= num_active_in;
            num_ovf_ff    <= num_ovf_in;
            line_error_ff <= line_error_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      stage_byte_ff <= stage_byte_in;
      rsp_status_ff <= rsp_status_in;
      rsp_media_ff  <= rsp_media_in;
      rsp_length_ff <= rsp_length_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_line_status = rsp_status_ff;
   assign rsp_media_type  = rsp_media_ff;
   assign rsp_body_length = rsp_length_ff;

   // A length is reported only with a content length line, a media type only
   // with a content type line.
   `HHLP_ASSERT_IMPLY(a_length_only_for_length, clock, reset, rsp_valid && rsp_line_status != hhlp_pkg::STATUS_LENGTH, rsp_body_length == 32'd0)
   `HHLP_ASSERT_IMPLY(a_media_only_for_type, clock, reset, rsp_valid && rsp_line_status != hhlp_pkg::STATUS_TYPE, rsp_media_type == hhlp_pkg::MEDIA_UNKNOWN)
   // After a line result the parser is back at the start of a key.
   `HHLP_ASSERT_NEXT(a_line_restart, clock, reset, advance && res_valid, phase_ff == hhlp_pkg::PH_KEY && pos_ff == 5'd0 && line_error_ff == 1'b0)

endmodule

@@ test/http_header_line_parser_tb.sv @@
module http_header_line_parser_tb;

   localparam int LENGTH_BITS = 32;
   localparam longint unsigned LENGTH_MAX = (64'd1 << LENGTH_BITS) - 64'd1;
   localparam int RANDOM_WORDS = 1150;
   localparam int QUIET_LIMIT = 1000;
   localparam int DRAIN_CYCLES = 8;

   typedef struct packed {
      logic [2:0]  status;
      logic [2:0]  media;
      logic [31:0] length;
   } line_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_line_status;
   logic [2:0]  rsp_media_type;
   logic [31:0] rsp_body_length;

   logic [7:0]      pending_words [$];
   line_result_type expected_lines [$];
   line_result_type oldest_line;
   int words_queued = 0;
   int words_accepted = 0;
   int failures = 0;
   int quiet_cycles = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   // Line parser state as the block should hold it.
   hhlp_pkg::phase_type line_phase = hhlp_pkg::PH_KEY;
   int unsigned     char_index = 0;
   logic [1:0]      key_live = 2'b11;
   logic [3:0]      media_live = 4'b1111;
   logic [3:0]      media_done = 4'b0000;
   longint unsigned number = 0;
   logic            digits_on = 1'b1;
   logic            number_over = 1'b0;
   logic            line_bad = 1'b0;

   http_header_line_parser #(
      .LENGTH_BITS(LENGTH_BITS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data_byte(req_data_byte),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_line_status(rsp_line_status),
      .rsp_media_type(rsp_media_type),
      .rsp_body_length(rsp_body_length)
   );

   always #1 clock = ~clock;

   function automatic string key_name(input int k);
      if (k == 0) begin
         return "content-type";
      end
      return "content-length";
   endfunction

   function automatic string media_name(input int k);
      case (k)
         0: begin
            return "text/plain";
         end
         1: begin
            return "application/octet-stream";
         end
         2: begin
            return "application/json";
         end
         default: begin
            return "application/td+json";
         end
      endcase
   endfunction

   task automatic record_line(input logic [2:0] status, input logic [2:0] media,
                              input logic [31:0] length);
      line_result_type entry;
      entry.status = status;
      entry.media = media;
      entry.length = length;
      expected_lines.push_back(entry);
      line_phase = hhlp_pkg::PH_KEY;
      char_index = 0;
      key_live = 2'b11;
      media_live = 4'b1111;
      media_done = 4'b0000;
      number = 0;
      digits_on = 1'b1;
      number_over = 1'b0;
      line_bad = 1'b0;
   endtask

   task automatic finish_line();
      logic [2:0] media;
      if (line_bad) begin
         record_line(hhlp_pkg::STATUS_MALFORMED, hhlp_pkg::MEDIA_UNKNOWN, 32'd0);
      end else if (key_live[0]) begin
         // The completed media type with the lowest code wins.
         media = hhlp_pkg::MEDIA_UNKNOWN;
         for (int k = 3; k >= 0; k--) begin
            if (media_done[k]) begin
               media = 3'(k + 1);
            end
         end
         record_line(hhlp_pkg::STATUS_TYPE, media, 32'd0);
      end else if (key_live[1]) begin
         if (number_over) begin
            record_line(hhlp_pkg::STATUS_MALFORMED, hhlp_pkg::MEDIA_UNKNOWN, 32'd0);
         end else begin
            record_line(hhlp_pkg::STATUS_LENGTH, hhlp_pkg::MEDIA_UNKNOWN, number[31:0]);
         end
      end else begin
         record_line(hhlp_pkg::STATUS_OTHER, hhlp_pkg::MEDIA_UNKNOWN, 32'd0);
      end
   endtask

   // A blank or CR ends the value text; a later non-blank undoes any match.
   task automatic close_value();
      string text;
      for (int k = 0; k < 4; k++) begin
         text = media_name(k);
         if (media_live[k] && char_index == text.len()) begin
            media_done[k] = 1'b1;
         end
      end
      media_live = 4'b0000;
      digits_on = 1'b0;
   endtask

   task automatic key_octet(input logic [7:0] c, input logic [7:0] lc);
      string text;
      if (c == hhlp_pkg::CHAR_LF) begin
         record_line(hhlp_pkg::STATUS_MALFORMED, hhlp_pkg::MEDIA_UNKNOWN, 32'd0);
      end else if (c == hhlp_pkg::CHAR_COLON) begin
         for (int k = 0; k < 2; k++) begin
            text = key_name(k);
            if (char_index != text.len()) begin
               key_live[k] = 1'b0;
            end
         end
         char_index = 0;
         line_phase = hhlp_pkg::PH_LEAD;
      end else begin
         if (c == hhlp_pkg::CHAR_CR && char_index == 0) begin
            line_phase = hhlp_pkg::PH_START_CR;
         end
         for (int k = 0; k < 2; k++) begin
            text = key_name(k);
            if (char_index >= text.len() || text[char_index] != lc) begin
               key_live[k] = 1'b0;
            end
         end
         if (char_index < 31) begin
            char_index++;
         end
      end
   endtask

   task automatic parse_octet(input logic [7:0] c);
      logic [7:0] lc;
      longint unsigned digit;
      string text;
      lc = (c >= hhlp_pkg::CHAR_UPPER_A && c <= hhlp_pkg::CHAR_UPPER_Z) ? c + 8'd32 : c;
      case (line_phase) inside
         hhlp_pkg::PH_START_CR: begin
            if (c == hhlp_pkg::CHAR_LF) begin
               record_line(hhlp_pkg::STATUS_END, hhlp_pkg::MEDIA_UNKNOWN, 32'd0);
            end else begin
               // A lone CR at line start was only a key word after all.
               line_phase = hhlp_pkg::PH_KEY;
               key_octet(c, lc);
            end
         end
         hhlp_pkg::PH_KEY: begin
            key_octet(c, lc);
         end
         hhlp_pkg::PH_LEAD, hhlp_pkg::PH_VAL: begin
            if (c == hhlp_pkg::CHAR_LF) begin
               record_line(hhlp_pkg::STATUS_MALFORMED, hhlp_pkg::MEDIA_UNKNOWN, 32'd0);
            end else if (c == hhlp_pkg::CHAR_CR) begin
               close_value();
               line_phase = hhlp_pkg::PH_CR;
            end else if (c == hhlp_pkg::CHAR_SPACE || c == hhlp_pkg::CHAR_TAB) begin
               if (line_phase == hhlp_pkg::PH_VAL) begin
                  close_value();
               end
            end else begin
               line_phase = hhlp_pkg::PH_VAL;
               media_done = 4'b0000;
               for (int k = 0; k < 4; k++) begin
                  text = media_name(k);
                  if (char_index >= text.len() || text[char_index] != lc) begin
                     media_live[k] = 1'b0;
                  end
               end
               if (char_index < 31) begin
                  char_index++;
               end
               if (digits_on) begin
                  if (c >= hhlp_pkg::CHAR_ZERO && c <= hhlp_pkg::CHAR_NINE) begin
                     digit = longint'(c - hhlp_pkg::CHAR_ZERO);
                     if (number > (LENGTH_MAX - digit) / 10) begin
                        number_over = 1'b1;
                     end else begin
                        number = number * 10 + digit;
                     end
                  end else begin
                     digits_on = 1'b0;
                  end
               end
            end
         end
         hhlp_pkg::PH_CR: begin
            if (c == hhlp_pkg::CHAR_LF) begin
               finish_line();
            end else begin
               line_bad = 1'b1;
               line_phase = hhlp_pkg::PH_SKIP;
            end
         end
         default: begin
            if (c == hhlp_pkg::CHAR_LF) begin
               line_bad = 1'b1;
               finish_line();
            end
         end
      endcase
   endtask

   task automatic push_text(input string s, input bit mix_case);
      logic [7:0] c;
      for (int i = 0; i < s.len(); i++) begin
         c = s[i];
         if (mix_case && ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z"))
             && $urandom_range(3) == 0) begin
            c = c ^ 8'h20;
         end
         pending_words.push_back(c);
      end
   endtask

   task automatic push_blanks(input int count);
      repeat (count) begin
         pending_words.push_back(($urandom_range(1) == 0) ?
                                 hhlp_pkg::CHAR_SPACE : hhlp_pkg::CHAR_TAB);
      end
   endtask

   // Random words in a range; LF is left out so that line boundaries stay put.
   task automatic push_random(input int count, input logic [7:0] lo, input logic [7:0] hi);
      logic [7:0] c;
      repeat (count) begin
         do begin
            c = 8'($urandom_range(hi, lo));
         end while (c == hhlp_pkg::CHAR_LF);
         pending_words.push_back(c);
      end
   endtask

   task automatic wait_for_words(input int count);
      while (words_accepted < count && quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            parse_octet(req_data_byte);
            words_accepted += 1;
         end
         if (!req_valid || !req_stall) begin
            if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_data_byte <= pending_words.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_lines.size() == 0) begin
               $error("result with no line pending: line_status %0d", rsp_line_status);
               failures++;
            end else begin
               oldest_line = expected_lines.pop_front();
               if (rsp_line_status !== oldest_line.status) begin
                  $error("line_status: expected %0d, got %0d",
                         oldest_line.status, rsp_line_status);
                  failures++;
               end
               if (rsp_media_type !== oldest_line.media) begin
                  $error("media_type: expected %0d, got %0d",
                         oldest_line.media, rsp_media_type);
                  failures++;
               end
               if (rsp_body_length !== oldest_line.length) begin
                  $error("body_length: expected %0d, got %0d",
                         oldest_line.length, rsp_body_length);
                  failures++;
               end
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int kind;
      int pick;
      int words_target;
      string text;

      // End of headers, extreme octets in a key with an empty value, a line
      // without a colon, a lone CR opening a key with LF but no CR after the
      // value, a CR not followed by LF, and an all-blank value.
      push_text("\015\n", 0);
      pending_words.push_back(8'h00);
      pending_words.push_back(8'hFF);
      push_text(":\015\n", 0);
      push_text("a\n", 0);
      push_text("\015k: x\n", 0);
      push_text("x:\015\015\n", 0);
      push_text("k:\t \015\n", 0);

      words_target = pending_words.size() + RANDOM_WORDS;
      while (pending_words.size() < words_target) begin
         kind = $urandom_range(99);
         if (kind < 35) begin
            push_text((kind < 32) ? "content-type" : "content-typ", 1);
            pending_words.push_back(hhlp_pkg::CHAR_COLON);
            push_blanks($urandom_range(2));
            pick = $urandom_range(9);
            text = media_name($urandom_range(3));
            if (pick < 6) begin
               push_text(text, 1);
            end else if (pick == 6) begin
               push_text(text.substr(0, $urandom_range(text.len() - 2)), 1);
            end else if (pick == 7) begin
               push_text(text, 1);
               push_blanks(1);
               push_text("charset=utf-8", 0);
            end else if (pick == 8) begin
               push_random($urandom_range(1, 12), 8'h21, 8'h7E);
            end
            push_blanks($urandom_range(2));
            push_text("\015\n", 0);
         end else if (kind < 65) begin
            push_text("content-length", 1);
            pending_words.push_back(hhlp_pkg::CHAR_COLON);
            push_blanks($urandom_range(2));
            pick = $urandom_range(9);
            if (pick < 5) begin
               push_random($urandom_range(1, 9), hhlp_pkg::CHAR_ZERO, hhlp_pkg::CHAR_NINE);
            end else if (pick == 5) begin
               push_text("4294967295", 0);
            end else if (pick == 6) begin
               push_text("4294967296", 0);
            end else if (pick == 7) begin
               push_random($urandom_range(10, 12), hhlp_pkg::CHAR_ZERO, hhlp_pkg::CHAR_NINE);
            end else if (pick == 8) begin
               push_text(($urandom_range(1) == 0) ? "+" : "-", 0);
               push_random($urandom_range(1, 3), hhlp_pkg::CHAR_ZERO, hhlp_pkg::CHAR_NINE);
            end
            if ($urandom_range(3) == 0) begin
               push_random($urandom_range(1, 4), 8'h21, 8'h7E);
            end
            push_blanks($urandom_range(2));
            push_text("\015\n", 0);
         end else if (kind < 80) begin
            push_random($urandom_range(1, 8), 8'h21, 8'h7E);
            pending_words.push_back(hhlp_pkg::CHAR_COLON);
            push_blanks($urandom_range(2));
            push_random($urandom_range(10), 8'h21, 8'h7E);
            push_blanks($urandom_range(2));
            push_text("\015\n", 0);
         end else if (kind < 85) begin
            push_text("\015\n", 0);
         end else begin
            pick = $urandom_range(3);
            if (pick == 0) begin
               push_random($urandom_range(20), 8'h00, 8'hFF);
               pending_words.push_back(hhlp_pkg::CHAR_LF);
            end else if (pick == 1) begin
               push_text("content-length: 12\n", 1);
            end else if (pick == 2) begin
               push_text("content-type: text/plain\015", 1);
               push_random($urandom_range(1, 4), 8'h00, 8'hFF);
               pending_words.push_back(hhlp_pkg::CHAR_LF);
            end else begin
               pending_words.push_back(hhlp_pkg::CHAR_CR);
               push_random($urandom_range(1, 6), 8'h00, 8'hFF);
               push_text(": x\015\n", 0);
            end
         end
      end
      words_queued = pending_words.size();

      send_idle_pct = 12;
      recv_idle_pct = 66;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      wait_for_words(words_queued / 3);
      send_idle_pct = 66;
      recv_idle_pct = 12;
      wait_for_words(2 * words_queued / 3);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      wait_for_words(words_queued);
      while (expected_lines.size() != 0 && quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (quiet_cycles >= QUIET_LIMIT) begin
         $error("no word moved on either side for %0d cycles", QUIET_LIMIT);
         failures++;
      end
      if (expected_lines.size() != 0) begin
         $error("%0d lines were never reported", expected_lines.size());
         failures++;
      end
      if (failures == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule
